FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mqpp_pkg.sv
// Types, codes and constants of the MQTT receive publish parser.
`default_nettype none

package mqpp_pkg;

  localparam int PREFIX_BYTES_DEF = 24;
  localparam int PREFIX_REG_BYTES = 24;   // prefix bytes held in the three registers

  localparam logic [7:0] MAX_TOPIC_LEN_RST   = 8'd160;
  localparam logic [7:0] PAYLOAD_LIMIT_RST   = 8'd255;
  localparam logic [27:0] MAX_COVER_RST      = 28'd262144;
  localparam logic [7:0] COVER_MIN_BYTES     = 8'd128;
  localparam logic [7:0] JPEG_SOI_0          = 8'hff;
  localparam logic [7:0] JPEG_SOI_1          = 8'hd8;
  localparam logic [3:0] PKT_PUBLISH         = 4'd3;
  localparam logic [3:0] PKT_PINGRESP        = 4'd13;

  // Suffix tracker: count of "cover" letters matched, or mismatch.
  localparam logic [2:0] SFX_FULL     = 3'd5;
  localparam logic [2:0] SFX_MISMATCH = 3'd6;

  // Result event codes.
  localparam logic [2:0] EV_NAME     = 3'd0;
  localparam logic [2:0] EV_NAME_END = 3'd1;
  localparam logic [2:0] EV_META     = 3'd2;
  localparam logic [2:0] EV_COVER    = 3'd3;
  localparam logic [2:0] EV_PING     = 3'd4;
  localparam logic [2:0] EV_ERROR    = 3'd5;
  localparam logic [2:0] EV_DROP     = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] REG_STREAM_MODE = 3'd0;
  localparam logic [2:0] REG_PREFIX_LEN  = 3'd1;
  localparam logic [2:0] REG_PREFIX_LO   = 3'd2;
  localparam logic [2:0] REG_PREFIX_MID  = 3'd3;
  localparam logic [2:0] REG_PREFIX_HI   = 3'd4;
  localparam logic [2:0] REG_MAX_TOPIC   = 3'd5;
  localparam logic [2:0] REG_PAY_LIMIT   = 3'd6;
  localparam logic [2:0] REG_MAX_COVER   = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic       last;
    logic       cover_ok;
  } out_item_t;

  typedef logic [PREFIX_REG_BYTES-1:0][7:0] prefix_bytes_t;

  typedef struct packed {
    logic       in_prefix;   // byte lies inside the configured prefix
    logic       byte_eq;     // byte equals the prefix byte at its position
    logic [2:0] sfx_nxt;     // suffix tracker after this byte
  } topic_match_t;

  function automatic logic [7:0] cover_letter(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h63;  // c
      3'd1:    c = 8'h6f;  // o
      3'd2:    c = 8'h76;  // v
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h72;  // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mqpp_topic_match.sv
// Per-byte topic check: prefix compare and "cover" suffix tracking.
`default_nettype none

module mqpp_topic_match (
  input  wire logic [7:0]             pos,
  input  wire logic [4:0]             plen,
  input  wire logic [7:0]             rx_byte,
  input  wire logic [2:0]             sfx,
  input  wire mqpp_pkg::prefix_bytes_t prefix,
  output mqpp_pkg::topic_match_t      match
);

  logic [7:0] sfx_pos;
  logic [7:0] pfx_byte;

  assign sfx_pos = pos - {3'b000, plen};

  always_comb begin
    // positions whose low five bits lie beyond the register-held prefix compare against zero
    if (pos[4:0] < 5'(mqpp_pkg::PREFIX_REG_BYTES)) begin
      pfx_byte = prefix[pos[4:0]];
    end else begin
      pfx_byte = 8'h00;
    end
  end

  always_comb begin
    match.in_prefix = pos < {3'b000, plen};
    match.byte_eq   = (rx_byte == pfx_byte);
    if (sfx_pos < 8'd5 && sfx == sfx_pos[2:0] &&
        rx_byte == mqpp_pkg::cover_letter(sfx_pos[2:0])) begin
      match.sfx_nxt = sfx_pos[2:0] + 3'd1;
    end else begin
      match.sfx_nxt = mqpp_pkg::SFX_MISMATCH;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mqtt_receive_publish_parser_unit.sv
// Top level of the MQTT receive parser with PUBLISH topic filtering.
`default_nettype none

// MQTT receive parser. Takes one broker byte per request and walks the MQTT
// framing: fixed header, remaining length (one to four 7-bit groups), and for a
// PUBLISH the topic length, topic and packet id (QoS above zero). The first
// prefix_len topic bytes must match the configured prefix; the rest is the name.
// Metadata mode (stream_mode 0) emits name bytes, a name-end event on the last
// topic byte, and up to payload_limit payload bytes. Cover mode emits the
// payload of a topic whose name is exactly "cover", with cover_ok on its last
// byte. Both modes also emit drop events. PINGRESP is reported; other packets
// are drained silently; a malformed length or short publish reports an error
// and halts until link close (kind 1). Each request produces zero or one result.
// Rate: one request per cycle; the parser state update and the result register
// sit in a single stage, and in_ready stays high while the result register is
// empty or being taken. Write configuration only while idle.
module mqtt_receive_publish_parser_unit #(
  parameter int PREFIX_BYTES = mqpp_pkg::PREFIX_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mqpp_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mqpp_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);

  typedef enum logic [8:0] {
    PH_HDR     = 9'b000000001,
    PH_LEN     = 9'b000000010,
    PH_TLEN_HI = 9'b000000100,
    PH_TLEN_LO = 9'b000001000,
    PH_TOPIC   = 9'b000010000,
    PH_PKTID   = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_DRAIN   = 9'b010000000,
    PH_HALT    = 9'b100000000
  } phase_t;

  // configuration registers
  logic        stream_mode_r;
  logic [4:0]  prefix_len_r;
  logic [2:0][63:0] prefix_r;
  logic [7:0]  max_topic_len_r;
  logic [7:0]  payload_limit_r;
  logic [27:0] max_cover_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [1:0]  len_idx_r, len_idx_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  tpos_r, tpos_nxt;
  logic        pfx_ok_r, pfx_ok_nxt;
  logic [2:0]  sfx_r, sfx_nxt;
  logic [1:0]  pid_left_r, pid_left_nxt;
  logic [27:0] pay_cnt_r, pay_cnt_nxt;
  logic [27:0] fwd_cnt_r, fwd_cnt_nxt;
  logic        jpeg_ok_r, jpeg_ok_nxt;

  // result register
  logic                 out_valid_r;
  mqpp_pkg::out_item_t  out_data_r;

  logic                 accept;
  logic                 emit;
  mqpp_pkg::out_item_t  res;

  logic [4:0]  plen;
  logic [7:0]  b;
  logic [1:0]  qos;
  logic [27:0] rem_dec;
  logic [27:0] pay;
  logic [27:0] limit_ext;
  logic [27:0] len_group;
  logic [27:0] rem_len;
  logic [15:0] tlen_full;
  logic        topic_last;
  logic        pfx_ok_now;
  logic [27:0] pay_inc;
  logic        pay_fin;
  logic        jpeg_new;
  logic [27:0] fwd_sel;

  mqpp_pkg::topic_match_t tm;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp the prefix length to the supported prefix size
  always_comb begin
    if ({1'b0, prefix_len_r} > 6'(PREFIX_BYTES)) begin
      plen = 5'(PREFIX_BYTES);
    end else begin
      plen = prefix_len_r;
    end
  end

  mqpp_topic_match u_match (
    .pos     (tpos_r),
    .plen    (plen),
    .rx_byte (in_data.rx_byte),
    .sfx     (sfx_r),
    .prefix  (mqpp_pkg::prefix_bytes_t'(prefix_r)),
    .match   (tm)
  );

  assign b         = in_data.rx_byte;
  assign qos       = header_r[2:1];
  assign rem_dec   = rem_r - 28'd1;
  assign pay       = rem_dec - ((qos != 2'd0) ? 28'd2 : 28'd0);
  assign limit_ext = {20'd0, payload_limit_r};
  assign tlen_full = {tlen_r[15:8], b};
  assign topic_last = (16'({1'b0, tpos_r}) + 16'd1) >= tlen_r;
  assign pfx_ok_now = pfx_ok_r && !(tm.in_prefix && !tm.byte_eq);
  assign pay_inc   = pay_cnt_r + 28'd1;
  assign pay_fin   = pay_inc >= fwd_cnt_r;
  assign rem_len   = rem_r | len_group;

  always_comb begin
    case (len_idx_r)
      2'd0:    len_group = {21'd0, b[6:0]};
      2'd1:    len_group = {14'd0, b[6:0], 7'd0};
      2'd2:    len_group = {7'd0, b[6:0], 14'd0};
      default: len_group = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    if (pay_cnt_r == 28'd0) begin
      jpeg_new = (b == mqpp_pkg::JPEG_SOI_0);
    end else if (pay_cnt_r == 28'd1) begin
      jpeg_new = jpeg_ok_r && (b == mqpp_pkg::JPEG_SOI_1);
    end else begin
      jpeg_new = jpeg_ok_r;
    end
  end

  // parser next state and result
  always_comb begin
    phase_nxt    = phase_r;
    header_nxt   = header_r;
    rem_nxt      = rem_r;
    len_idx_nxt  = len_idx_r;
    tlen_nxt     = tlen_r;
    tpos_nxt     = tpos_r;
    pfx_ok_nxt   = pfx_ok_r;
    sfx_nxt      = sfx_r;
    pid_left_nxt = pid_left_r;
    pay_cnt_nxt  = pay_cnt_r;
    fwd_cnt_nxt  = fwd_cnt_r;
    jpeg_ok_nxt  = jpeg_ok_r;
    fwd_sel      = 28'd0;
    emit         = 1'b0;
    res          = '0;

    if (in_data.kind) begin
      // link closed: return the parser to its reset state
      phase_nxt    = PH_HDR;
      header_nxt   = 8'd0;
      rem_nxt      = 28'd0;
      len_idx_nxt  = 2'd0;
      tlen_nxt     = 16'd0;
      tpos_nxt     = 8'd0;
      pfx_ok_nxt   = 1'b1;
      sfx_nxt      = 3'd0;
      pid_left_nxt = 2'd0;
      pay_cnt_nxt  = 28'd0;
      fwd_cnt_nxt  = 28'd0;
      jpeg_ok_nxt  = 1'b0;
    end else begin
      case (phase_r)
        PH_HDR: begin
          header_nxt  = b;
          rem_nxt     = 28'd0;
          len_idx_nxt = 2'd0;
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          rem_nxt = rem_len;
          if (b[7]) begin
            if (len_idx_r == 2'd3) begin
              phase_nxt     = PH_HALT;
              emit          = 1'b1;
              res.event_res = mqpp_pkg::EV_ERROR;
            end else begin
              len_idx_nxt = len_idx_r + 2'd1;
            end
          end else if (header_r[7:4] == mqpp_pkg::PKT_PUBLISH) begin
            if (rem_len < 28'd2) begin
              phase_nxt     = PH_HALT;
              emit          = 1'b1;
              res.event_res = mqpp_pkg::EV_ERROR;
            end else begin
              phase_nxt = PH_TLEN_HI;
            end
          end else begin
            phase_nxt = (rem_len != 28'd0) ? PH_DRAIN : PH_HDR;
            if (header_r[7:4] == mqpp_pkg::PKT_PINGRESP) begin
              emit          = 1'b1;
              res.event_res = mqpp_pkg::EV_PING;
            end
          end
        end
        PH_TLEN_HI: begin
          tlen_nxt  = {b, 8'd0};
          rem_nxt   = rem_dec;
          phase_nxt = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          tlen_nxt = tlen_full;
          rem_nxt  = rem_dec;
          if (tlen_full == 16'd0 || tlen_full > {8'd0, max_topic_len_r} ||
              {12'd0, tlen_full} > rem_dec) begin
            phase_nxt = (rem_dec != 28'd0) ? PH_DRAIN : PH_HDR;
          end else begin
            tpos_nxt   = 8'd0;
            sfx_nxt    = 3'd0;
            pfx_ok_nxt = {11'd0, plen} <= tlen_full;
            phase_nxt  = PH_TOPIC;
          end
        end
        PH_TOPIC: begin
          rem_nxt    = rem_dec;
          pfx_ok_nxt = pfx_ok_now;
          if (!tm.in_prefix) begin
            sfx_nxt = tm.sfx_nxt;
          end
          tpos_nxt = tpos_r + 8'd1;
          if (topic_last) begin
            if (qos != 2'd0 && rem_dec < 28'd2) begin
              // short publish: no room for the packet id
              phase_nxt     = PH_HALT;
              emit          = 1'b1;
              res.event_res = mqpp_pkg::EV_ERROR;
            end else begin
              pay_cnt_nxt = 28'd0;
              jpeg_ok_nxt = 1'b0;
              if (pfx_ok_now) begin
                if (!stream_mode_r) begin
                  if (tm.sfx_nxt == mqpp_pkg::SFX_FULL && !tm.in_prefix ||
                      tlen_r == {11'd0, plen}) begin
                    emit          = 1'b1;
                    res.event_res = mqpp_pkg::EV_DROP;
                  end else begin
                    fwd_sel       = (pay < limit_ext) ? pay : limit_ext;
                    emit          = 1'b1;
                    res.event_res = mqpp_pkg::EV_NAME_END;
                    res.data_byte = b;
                    res.last      = (fwd_sel == 28'd0);
                  end
                end else if (tm.sfx_nxt == mqpp_pkg::SFX_FULL && !tm.in_prefix) begin
                  if (pay == 28'd0 || pay > max_cover_r) begin
                    emit          = 1'b1;
                    res.event_res = mqpp_pkg::EV_DROP;
                  end else begin
                    fwd_sel = pay;
                  end
                end
              end
              fwd_cnt_nxt = fwd_sel;
              if (fwd_sel != 28'd0 && qos != 2'd0) begin
                pid_left_nxt = 2'd2;
                phase_nxt    = PH_PKTID;
              end else if (fwd_sel != 28'd0) begin
                phase_nxt = PH_PAYLOAD;
              end else begin
                phase_nxt = (rem_dec != 28'd0) ? PH_DRAIN : PH_HDR;
              end
            end
          end else if (!stream_mode_r && pfx_ok_now && !tm.in_prefix) begin
            emit          = 1'b1;
            res.event_res = mqpp_pkg::EV_NAME;
            res.data_byte = b;
          end
        end
        PH_PKTID: begin
          rem_nxt      = rem_dec;
          pid_left_nxt = pid_left_r - 2'd1;
          if (pid_left_r == 2'd1) begin
            if (fwd_cnt_r != 28'd0) begin
              phase_nxt = PH_PAYLOAD;
            end else begin
              phase_nxt = (rem_dec != 28'd0) ? PH_DRAIN : PH_HDR;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_nxt     = rem_dec;
          pay_cnt_nxt = pay_inc;
          if (pay_fin) begin
            phase_nxt = (rem_dec != 28'd0) ? PH_DRAIN : PH_HDR;
          end
          emit          = 1'b1;
          res.data_byte = b;
          res.last      = pay_fin;
          if (sfx_r == mqpp_pkg::SFX_FULL) begin
            jpeg_ok_nxt   = jpeg_new;
            res.event_res = mqpp_pkg::EV_COVER;
            res.cover_ok  = pay_fin && jpeg_new &&
                            (fwd_cnt_r >= {20'd0, mqpp_pkg::COVER_MIN_BYTES});
          end else begin
            res.event_res = mqpp_pkg::EV_META;
          end
        end
        PH_DRAIN: begin
          // drop bytes until the packet is used up
          if (rem_r != 28'd0) begin
            rem_nxt = rem_dec;
          end
          if (rem_r <= 28'd1) begin
            phase_nxt = PH_HDR;
          end
        end
        default: begin
          // halted: ignore bytes until the link closes
        end
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_mode_r   <= 1'b0;
      prefix_len_r    <= 5'd0;
      prefix_r        <= '0;
      max_topic_len_r <= mqpp_pkg::MAX_TOPIC_LEN_RST;
      payload_limit_r <= mqpp_pkg::PAYLOAD_LIMIT_RST;
      max_cover_r     <= mqpp_pkg::MAX_COVER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mqpp_pkg::REG_STREAM_MODE: stream_mode_r   <= cfg_wdata[0];
        mqpp_pkg::REG_PREFIX_LEN:  prefix_len_r    <= cfg_wdata[4:0];
        mqpp_pkg::REG_PREFIX_LO:   prefix_r[0]     <= cfg_wdata;
        mqpp_pkg::REG_PREFIX_MID:  prefix_r[1]     <= cfg_wdata;
        mqpp_pkg::REG_PREFIX_HI:   prefix_r[2]     <= cfg_wdata;
        mqpp_pkg::REG_MAX_TOPIC:   max_topic_len_r <= cfg_wdata[7:0];
        mqpp_pkg::REG_PAY_LIMIT:   payload_limit_r <= cfg_wdata[7:0];
        mqpp_pkg::REG_MAX_COVER:   max_cover_r     <= cfg_wdata[27:0];
        default: begin
        end
      endcase
    end
  end

  // parser state: advance only on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR;
      header_r   <= 8'd0;
      rem_r      <= 28'd0;
      len_idx_r  <= 2'd0;
      tlen_r     <= 16'd0;
      tpos_r     <= 8'd0;
      pfx_ok_r   <= 1'b1;
      sfx_r      <= 3'd0;
      pid_left_r <= 2'd0;
      pay_cnt_r  <= 28'd0;
      fwd_cnt_r  <= 28'd0;
      jpeg_ok_r  <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      header_r   <= header_nxt;
      rem_r      <= rem_nxt;
      len_idx_r  <= len_idx_nxt;
      tlen_r     <= tlen_nxt;
      tpos_r     <= tpos_nxt;
      pfx_ok_r   <= pfx_ok_nxt;
      sfx_r      <= sfx_nxt;
      pid_left_r <= pid_left_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      fwd_cnt_r  <= fwd_cnt_nxt;
      jpeg_ok_r  <= jpeg_ok_nxt;
    end
  end

  // result register: on an accepted request, valid if it emits; else clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mqpp_checker.sv
// Port-level checker for the MQTT receive parser, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module mqpp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mqpp_pkg::out_item_t out_data
);

  // a stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // an empty result register never blocks requests
  `ASSERT_CLK_RST(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input blocked while output empty")

  // cover verdict only on the last cover byte
  `ASSERT_CLK_RST(a_cover_ok, clk, rst_n, out_valid && out_data.cover_ok |-> out_data.last && out_data.event_res == mqpp_pkg::EV_COVER, "cover_ok outside last cover byte")

  // last only on payload bytes or name end
  `ASSERT_CLK_RST(a_last_kind, clk, rst_n, out_valid && out_data.last |-> out_data.event_res == mqpp_pkg::EV_META || out_data.event_res == mqpp_pkg::EV_COVER || out_data.event_res == mqpp_pkg::EV_NAME_END, "last on wrong event")

endmodule

bind mqtt_receive_publish_parser_unit mqpp_checker u_mqpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench of the MQTT receive publish parser: directed and random broker byte streams.
module testbench;
  import mqpp_pkg::*;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    P_HDR, P_LEN, P_TLEN_HI, P_TLEN_LO, P_TOPIC, P_PKTID, P_PAYLOAD, P_DRAIN, P_HALT
  } parse_phase_e;

  // Topic suffix that selects the cover image stream, first letter in the top byte.
  localparam logic [39:0] COVER_WORD = "cover";

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  mqtt_receive_publish_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copy held by the predictor.
  logic        cfg_mode;
  logic [4:0]  cfg_prefix_len;
  logic [63:0] cfg_prefix [3];
  logic [7:0]  cfg_max_topic;
  logic [7:0]  cfg_pay_limit;
  logic [27:0] cfg_max_cover;

  // Parser state held by the predictor.
  parse_phase_e ph;
  logic [7:0]   hdr;
  logic [27:0]  rem;
  logic [1:0]   lidx;
  logic [15:0]  tlen;
  logic [7:0]   tpos;
  logic         pfx_ok;
  logic [2:0]   sfx;
  logic [1:0]   pid;
  logic [27:0]  pcnt;
  logic [27:0]  fwd;
  logic         jpeg;

  // Events the parser still owes, oldest first.
  out_item_t pending_events [$];

  // Requests of the message being built, and scratch queues for its parts.
  in_item_t   frame_q [$];
  logic [7:0] body_q [$];
  logic [7:0] topic_q [$];

  int accepted_requests;
  int err_count;
  int send_gap_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: stall at random with the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int effective_prefix_len();
    return (cfg_prefix_len > PREFIX_BYTES_DEF) ? PREFIX_BYTES_DEF : int'(cfg_prefix_len);
  endfunction

  // Prefix bytes past the three registers read as zero.
  function automatic logic [7:0] prefix_at(input int i);
    if (i >= PREFIX_REG_BYTES) return 8'h00;
    return cfg_prefix[i / 8][8 * (i % 8) +: 8];
  endfunction

  function automatic out_item_t make_event(input logic [2:0] code, input logic [7:0] d,
                                           input logic l, input logic ok);
    out_item_t e;
    e.event_res = code;
    e.data_byte = d;
    e.last      = l;
    e.cover_ok  = ok;
    return e;
  endfunction

  function automatic void clear_parser();
    ph     = P_HDR;
    hdr    = '0;
    rem    = '0;
    lidx   = '0;
    tlen   = '0;
    tpos   = '0;
    pfx_ok = 1'b1;
    sfx    = '0;
    pid    = '0;
    pcnt   = '0;
    fwd    = '0;
    jpeg   = 1'b0;
  endfunction

  // Drain the rest of the packet, or wait for the next header when nothing remains.
  function automatic void enter_drain();
    ph = (rem != 0) ? P_DRAIN : P_HDR;
  endfunction

  // Advance the parser by one request; return 1 when it yields an event.
  function automatic bit parse_step(input in_item_t it, output out_item_t res);
    logic [7:0]  b;
    logic [1:0]  qos;
    logic [27:0] pay;
    logic [27:0] idx;
    int          p;
    int          eff;
    int          s;
    bit          fin;
    bit          is_cover;
    bit          emitted;
    b   = it.rx_byte;
    res = '0;
    eff = effective_prefix_len();
    if (it.kind) begin
      clear_parser();
      return 1'b0;
    end
    case (ph)
      P_HDR: begin
        hdr  = b;
        rem  = '0;
        lidx = '0;
        ph   = P_LEN;
      end
      P_LEN: begin
        rem = rem + (28'(b[6:0]) << (7 * lidx));
        if (b[7]) begin
          if (lidx == 2'd3) begin
            ph  = P_HALT;
            res = make_event(EV_ERROR, 8'h00, 1'b0, 1'b0);
            return 1'b1;
          end
          lidx = lidx + 2'd1;
        end else if (hdr[7:4] == PKT_PUBLISH) begin
          if (rem < 28'd2) begin
            ph  = P_HALT;
            res = make_event(EV_ERROR, 8'h00, 1'b0, 1'b0);
            return 1'b1;
          end
          ph = P_TLEN_HI;
        end else begin
          enter_drain();
          if (hdr[7:4] == PKT_PINGRESP) begin
            res = make_event(EV_PING, 8'h00, 1'b0, 1'b0);
            return 1'b1;
          end
        end
      end
      P_TLEN_HI: begin
        tlen = {b, 8'h00};
        rem  = rem - 28'd1;
        ph   = P_TLEN_LO;
      end
      P_TLEN_LO: begin
        tlen[7:0] = b;
        rem       = rem - 28'd1;
        if (tlen == 0 || tlen > cfg_max_topic || rem < tlen) begin
          enter_drain();
        end else begin
          tpos   = '0;
          sfx    = '0;
          pfx_ok = (eff <= tlen);
          ph     = P_TOPIC;
        end
      end
      P_TOPIC: begin
        p   = tpos;
        rem = rem - 28'd1;
        if (p < eff) begin
          if (b != prefix_at(p)) pfx_ok = 1'b0;
        end else begin
          s = p - eff;
          if (s < 5 && sfx == s && b == COVER_WORD[8 * (4 - s) +: 8]) sfx = 3'(s + 1);
          else sfx = SFX_MISMATCH;
        end
        tpos = 8'(p + 1);
        if (p + 1 >= tlen) begin
          // Last topic byte: settle what happens to the message.
          qos = hdr[2:1];
          if (qos != 0 && rem < 28'd2) begin
            ph  = P_HALT;
            res = make_event(EV_ERROR, 8'h00, 1'b0, 1'b0);
            return 1'b1;
          end
          pay      = rem - ((qos != 0) ? 28'd2 : 28'd0);
          is_cover = (sfx == SFX_FULL);
          fwd      = '0;
          pcnt     = '0;
          jpeg     = 1'b0;
          emitted  = 1'b0;
          if (pfx_ok) begin
            if (!cfg_mode) begin
              if (is_cover || tlen == eff) begin
                res     = make_event(EV_DROP, 8'h00, 1'b0, 1'b0);
                emitted = 1'b1;
              end else begin
                fwd     = (pay < cfg_pay_limit) ? pay : 28'(cfg_pay_limit);
                res     = make_event(EV_NAME_END, b, fwd == 0, 1'b0);
                emitted = 1'b1;
              end
            end else if (is_cover) begin
              if (pay == 0 || pay > cfg_max_cover) begin
                res     = make_event(EV_DROP, 8'h00, 1'b0, 1'b0);
                emitted = 1'b1;
              end else begin
                fwd = pay;
              end
            end
          end
          if (fwd != 0 && qos != 0) begin
            pid = 2'd2;
            ph  = P_PKTID;
          end else if (fwd != 0) begin
            ph = P_PAYLOAD;
          end else begin
            enter_drain();
          end
          return emitted;
        end else if (!cfg_mode && pfx_ok && p >= eff) begin
          res = make_event(EV_NAME, b, 1'b0, 1'b0);
          return 1'b1;
        end
      end
      P_PKTID: begin
        rem = rem - 28'd1;
        pid = pid - 2'd1;
        if (pid == 0) begin
          if (fwd != 0) ph = P_PAYLOAD;
          else enter_drain();
        end
      end
      P_PAYLOAD: begin
        idx  = pcnt;
        rem  = rem - 28'd1;
        pcnt = idx + 28'd1;
        fin  = (pcnt >= fwd);
        if (fin) enter_drain();
        if (sfx == SFX_FULL) begin
          if (idx == 0) jpeg = (b == JPEG_SOI_0);
          else if (idx == 1) jpeg = jpeg && (b == JPEG_SOI_1);
          res = make_event(EV_COVER, b, fin, fin && fwd >= COVER_MIN_BYTES && jpeg);
        end else begin
          res = make_event(EV_META, b, fin, 1'b0);
        end
        return 1'b1;
      end
      P_DRAIN: begin
        if (rem != 0) rem = rem - 28'd1;
        if (rem == 0) ph = P_HDR;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Send one request; hold it until accepted, then predict its event.
  task automatic send_request(input in_item_t item);
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_requests++;
    if (parse_step(item, res)) pending_events.push_back(res);
  endtask

  // Compare every taken event with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event %0d data %02h",
                                  out_data.event_res, out_data.data_byte));
      end else begin
        want = pending_events.pop_front();
        if (out_data.event_res !== want.event_res)
          report_mismatch($sformatf("event_res got %0d want %0d",
                                    out_data.event_res, want.event_res));
        if (out_data.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte got %02h want %02h",
                                    out_data.data_byte, want.data_byte));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", out_data.last, want.last));
        if (out_data.cover_ok !== want.cover_ok)
          report_mismatch($sformatf("cover_ok got %b want %b",
                                    out_data.cover_ok, want.cover_ok));
      end
    end
  end

  // Drop valid and wait until every owed event is out and the pipe is quiet.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STREAM_MODE: cfg_mode       = val[0];
      REG_PREFIX_LEN:  cfg_prefix_len = val[4:0];
      REG_PREFIX_LO:   cfg_prefix[0]  = val;
      REG_PREFIX_MID:  cfg_prefix[1]  = val;
      REG_PREFIX_HI:   cfg_prefix[2]  = val;
      REG_MAX_TOPIC:   cfg_max_topic  = val[7:0];
      REG_PAY_LIMIT:   cfg_pay_limit  = val[7:0];
      REG_MAX_COVER:   cfg_max_cover  = val[27:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic mode, input logic [4:0] plen, input logic [63:0] lo,
                           input logic [63:0] mid, input logic [63:0] hi,
                           input logic [7:0] mtopic, input logic [7:0] lim,
                           input logic [27:0] maxc);
    wait_idle();
    write_reg(REG_STREAM_MODE, 64'(mode));
    write_reg(REG_PREFIX_LEN, 64'(plen));
    write_reg(REG_PREFIX_LO, lo);
    write_reg(REG_PREFIX_MID, mid);
    write_reg(REG_PREFIX_HI, hi);
    write_reg(REG_MAX_TOPIC, 64'(mtopic));
    write_reg(REG_PAY_LIMIT, 64'(lim));
    write_reg(REG_MAX_COVER, 64'(maxc));
  endtask

  task automatic set_idling(input int round);
    case (round)
      0:       begin send_gap_pct = 8;  recv_stall_pct = 82; end
      1:       begin send_gap_pct = 82; recv_stall_pct = 8;  end
      default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Message building
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    frame_q.push_back(in_item_t'{kind: 1'b0, rx_byte: b});
  endtask

  task automatic push_close();
    frame_q.push_back(in_item_t'{kind: 1'b1, rx_byte: 8'($urandom)});
  endtask

  task automatic flush_frame();
    foreach (frame_q[i]) send_request(frame_q[i]);
    frame_q.delete();
  endtask

  // Mostly minimal length encodings, now and then padded with zero groups.
  function automatic int pick_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Push header, remaining length of body_q and the body itself.
  task automatic push_packet(input logic [7:0] hdr_b, input int pad);
    int groups;
    int total;
    int n;
    logic [7:0] g;
    n = body_q.size();
    groups = 1;
    while ((n >> (7 * groups)) != 0 && groups < 4) groups++;
    total = (groups + pad > 4) ? 4 : groups + pad;
    push_byte(hdr_b);
    for (int i = 0; i < total; i++) begin
      g = 8'((n >> (7 * i)) & 127);
      if (i < total - 1) g[7] = 1'b1;
      push_byte(g);
    end
    foreach (body_q[i]) push_byte(body_q[i]);
    body_q.delete();
  endtask

  // Well-formed PUBLISH whose topic mostly carries the configured prefix.
  task automatic build_publish(input bit favor_cover, input bit allow_big);
    logic [1:0] qos;
    int eff;
    int sel;
    int n;
    int pay;
    bit marker;
    qos = 2'($urandom_range(0, 3));
    eff = effective_prefix_len();
    topic_q.delete();
    for (int i = 0; i < eff; i++) topic_q.push_back(prefix_at(i));
    if (eff > 0 && $urandom_range(0, 19) == 0) begin
      n = $urandom_range(0, eff - 1);
      topic_q[n] = topic_q[n] ^ 8'(1 << $urandom_range(0, 7));
    end
    sel = $urandom_range(0, 9);
    if (sel <= (favor_cover ? 5 : 1)) begin
      for (int i = 0; i < 5; i++) topic_q.push_back(COVER_WORD[8 * (4 - i) +: 8]);
    end else if (sel == 7) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) topic_q.push_back(COVER_WORD[8 * (4 - i) +: 8]);
    end else if (sel == 8) begin
      for (int i = 0; i < 5; i++) topic_q.push_back(COVER_WORD[8 * (4 - i) +: 8]);
      topic_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
    end else if (sel != 6) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        topic_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7a))
                                               : 8'($urandom));
    end
    // Now and then make the topic shorter than the prefix.
    if (eff > 0 && $urandom_range(0, 19) == 0) begin
      n = $urandom_range(0, eff - 1);
      while (topic_q.size() > n) void'(topic_q.pop_back());
    end
    if (allow_big && $urandom_range(0, 7) == 0) pay = $urandom_range(126, 131);
    else if ($urandom_range(0, 4) == 0) pay = $urandom_range(7, 20);
    else pay = $urandom_range(0, 6);
    marker = ($urandom_range(0, 3) != 0);
    body_q.push_back(8'(topic_q.size() >> 8));
    body_q.push_back(8'(topic_q.size()));
    foreach (topic_q[i]) body_q.push_back(topic_q[i]);
    if (qos != 0) begin
      body_q.push_back(8'($urandom));
      body_q.push_back(8'($urandom));
    end
    for (int i = 0; i < pay; i++) begin
      if (marker && i == 0) body_q.push_back(JPEG_SOI_0);
      else if (marker && i == 1) body_q.push_back(JPEG_SOI_1);
      else body_q.push_back(8'($urandom));
    end
    push_packet({PKT_PUBLISH, 1'($urandom), qos, 1'($urandom)}, pick_pad());
  endtask

  // One message, mostly well-formed; the rest are pings, other packets and broken ones.
  task automatic gen_message(input bit favor_cover, input bit allow_big);
    int r;
    int n;
    int t;
    logic [3:0] ptype;
    logic [1:0] qos;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      build_publish(favor_cover, allow_big);
    end else if (r < 70) begin
      n = ($urandom_range(0, 9) == 0) ? 2 : 0;
      for (int i = 0; i < n; i++) body_q.push_back(8'($urandom));
      push_packet({PKT_PINGRESP, 4'($urandom)}, pick_pad());
    end else if (r < 78) begin
      do ptype = 4'($urandom); while (ptype == PKT_PUBLISH || ptype == PKT_PINGRESP);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) body_q.push_back(8'($urandom));
      push_packet({ptype, 4'($urandom)}, pick_pad());
    end else if (r < 83) begin
      // Topic length zero, too long, or longer than what remains.
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
        0:       t = 0;
        1:       t = int'(cfg_max_topic) + 1 + $urandom_range(0, 20);
        2:       t = $urandom_range(0, 65535);
        default: t = n + $urandom_range(1, 3);
      endcase
      body_q.push_back(8'(t >> 8));
      body_q.push_back(8'(t));
      for (int i = 0; i < n; i++) body_q.push_back(8'($urandom));
      push_packet({PKT_PUBLISH, 4'($urandom)}, pick_pad());
    end else if (r < 88) begin
      // Remaining length that would need a fifth byte.
      push_byte($urandom_range(0, 1) ? {PKT_PUBLISH, 4'($urandom)} : 8'($urandom));
      repeat (4) push_byte(8'h80 | 8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      push_close();
    end else if (r < 93) begin
      // Short publish: remaining length below two, or no room for the packet id.
      if ($urandom_range(0, 1)) begin
        push_byte({PKT_PUBLISH, 4'($urandom)});
        n = $urandom_range(0, 1);
        push_byte(8'(n));
        if (n != 0) push_byte(8'($urandom));
      end else begin
        qos = 2'($urandom_range(1, 3));
        t = $urandom_range(1, (cfg_max_topic < 4) ? int'(cfg_max_topic) : 4);
        body_q.push_back(8'h00);
        body_q.push_back(8'(t));
        for (int i = 0; i < t; i++) body_q.push_back(8'($urandom));
        if ($urandom_range(0, 1)) body_q.push_back(8'($urandom));
        push_packet({PKT_PUBLISH, 1'($urandom), qos, 1'($urandom)}, 0);
      end
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
      push_close();
    end else if (r < 97) begin
      // Link drops in the middle of a publish.
      build_publish(favor_cover, 1'b0);
      n = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > n) void'(frame_q.pop_back());
      push_close();
    end else begin
      repeat ($urandom_range(1, 6))
        frame_q.push_back(in_item_t'{kind: ($urandom_range(0, 3) == 0),
                                     rx_byte: 8'($urandom)});
      push_close();
    end
  endtask

  task automatic run_traffic(input bit favor_cover, input bit allow_big, input int budget);
    int start;
    start = accepted_requests;
    push_close();
    flush_frame();
    while (accepted_requests - start < budget) begin
      gen_message(favor_cover, allow_big);
      flush_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: ping, a short metadata publish, QoS 1 with no payload,
  // short publish and malformed length, each error cleared by a link close.
  task automatic test_reset_defaults();
    logic [7:0] seq [$];
    seq = '{8'hd0, 8'h00,
            8'h30, 8'h05, 8'h00, 8'h02, 8'h61, 8'h62, 8'hff,
            8'h32, 8'h05, 8'h00, 8'h01, 8'h78, 8'h12, 8'h34,
            8'h30, 8'h01, 8'h00, 8'h55};
    foreach (seq[i]) push_byte(seq[i]);
    push_close();
    push_byte(8'h30);
    repeat (4) push_byte(8'hff);
    push_close();
    flush_frame();
  endtask

  task automatic test_metadata_stream(input int round);
    logic [4:0] plen;
    logic [7:0] mtopic;
    logic [7:0] lim;
    plen   = (round == 0) ? 5'd0 : (round == 1) ? 5'd1 : 5'($urandom_range(2, 6));
    mtopic = (round == 0) ? 8'd255 : (round == 1) ? 8'd1 : 8'($urandom_range(8, 30));
    lim    = (round == 0) ? 8'd255 : (round == 1) ? 8'd0 : 8'($urandom_range(1, 5));
    configure(1'b0, plen, (round == 0) ? 64'd0 : {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, mtopic, lim, MAX_COVER_RST);
    run_traffic(1'b0, 1'b0, 110);
  endtask

  task automatic test_cover_stream(input int round);
    logic [27:0] big_limit [3];
    logic [27:0] small_limit [3];
    logic [7:0]  mtopic;
    big_limit   = '{28'hfffffff, 28'd128, 28'd131};
    small_limit = '{28'd0, 28'($urandom_range(1, 6)), 28'd200};
    mtopic = (round == 0) ? 8'd255 : (round == 1) ? MAX_TOPIC_LEN_RST
                                                  : 8'($urandom_range(20, 60));
    configure(1'b1, (round == 0) ? 5'd0 : 5'($urandom_range(1, 8)),
              {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              mtopic, 8'($urandom), big_limit[round]);
    run_traffic(1'b1, 1'b1, 110);
    // Same topics, new cover limit: zero, tight, or above every payload sent.
    wait_idle();
    write_reg(REG_MAX_COVER, 64'(small_limit[round]));
    run_traffic(1'b1, 1'b0, 80);
  endtask

  // Prefixes reaching into the middle and high registers and past their end.
  task automatic test_long_prefix(input int round);
    logic [4:0] plen;
    plen = (round == 0) ? 5'd24 : (round == 1) ? 5'd31 : 5'($urandom_range(9, 23));
    configure(1'($urandom), plen, {$urandom, $urandom}, {$urandom, $urandom},
              (round == 1) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom},
              (round == 2) ? 8'($urandom_range(40, 255)) : 8'd255,
              8'($urandom), 28'($urandom_range(1, 300)));
    run_traffic(1'($urandom), 1'b0, 90);
  endtask

  // Raw line noise with link closes mixed in.
  task automatic test_line_noise();
    push_close();
    repeat (40)
      frame_q.push_back(in_item_t'{kind: ($urandom_range(0, 9) == 0), rx_byte: 8'($urandom)});
    push_close();
    flush_frame();
  endtask

  // Run limit, far above the slowest expected run.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    accepted_requests = 0;
    err_count = 0;
    // Register values after reset, as the predictor sees them.
    cfg_mode       = 1'b0;
    cfg_prefix_len = '0;
    cfg_prefix     = '{64'd0, 64'd0, 64'd0};
    cfg_max_topic  = MAX_TOPIC_LEN_RST;
    cfg_pay_limit  = PAYLOAD_LIMIT_RST;
    cfg_max_cover  = MAX_COVER_RST;
    clear_parser();
    set_idling(0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    for (int round = 0; round < 3; round++) begin
      set_idling(round);
      test_metadata_stream(round);
      test_cover_stream(round);
      test_long_prefix(round);
      test_line_noise();
    end

    // Let every owed event arrive, then a few quiet cycles for strays.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mqpp_pkg.sv
hw/rtl/mqpp_topic_match.sv
hw/rtl/mqtt_receive_publish_parser_unit.sv
hw/rtl/mqpp_checker.sv
sim/testbench.sv
